// ----- sv/sd_pkg.sv -----
// Shared types and constants for the stillness detector.
`timescale 1ns / 1ps

package sd_pkg;

    // One standard gravity in Q8.8 m/s^2
    localparam int unsigned G_Q8_8    = 2511;
    localparam int unsigned US_PER_MS = 1000;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int ACCEL_W    = 16;
    localparam int TIME_W     = 32;
    localparam int SQ_W       = 31;   // square of a 16-bit signed value
    localparam int REF_W      = 33;   // g^2 + t^2
    localparam int LIM_W      = 29;   // 2*g*t
    localparam int US_W       = 26;   // 16-bit ms scaled to us
    localparam int ERR_W      = 9;
    localparam int MAXERR_W   = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT_MS      = 2'd0,
        CFG_MIN_STILL_MS    = 2'd1,
        CFG_STILL_THRESHOLD = 2'd2,
        CFG_MAX_ERRORS      = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OUT_RUNNING  = 3'd0,
        OUT_STILL    = 3'd1,
        OUT_MOVED    = 3'd2,
        OUT_DEADLINE = 3'd3,
        OUT_ERRORS   = 3'd4,
        OUT_IDLE     = 3'd5
    } outcome_t;

    typedef enum logic {
        CMD_START  = 1'b0,
        CMD_SAMPLE = 1'b1
    } command_t;

    localparam logic [REF_W-1:0]    THR_REF_RESET   = REF_W'(G_Q8_8 * G_Q8_8 + 26 * 26);
    localparam logic [LIM_W-1:0]    THR_LIM_RESET   = LIM_W'(2 * G_Q8_8 * 26);
    localparam logic [REF_W-1:0]    G_SQ            = REF_W'(G_Q8_8 * G_Q8_8);
    localparam logic [LIM_W-1:0]    TWO_G           = LIM_W'(2 * G_Q8_8);
    localparam logic [US_W-1:0]     TIMEOUT_US_RESET   = US_W'(1000 * US_PER_MS);
    localparam logic [US_W-1:0]     MIN_STILL_US_RESET = US_W'(500 * US_PER_MS);
    localparam logic [MAXERR_W-1:0] MAX_ERRORS_RESET   = 8'd100;

endpackage

// ----- sv/sd_if.sv -----
// Handshake channels of the stillness detector: sample requests, results, configuration.
`timescale 1ns / 1ps

interface sd_item_if
    import sd_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic                      sample_valid;
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
    logic [TIME_W-1:0]         now_us;

    modport source (output valid, command, sample_valid, accel_x, accel_y, accel_z, now_us,
                    input ready);
    modport sink   (input valid, command, sample_valid, accel_x, accel_y, accel_z, now_us,
                    output ready);
endinterface

interface sd_result_if
    import sd_pkg::*;
();
    logic     valid;
    logic     ready;
    logic     check_done;
    logic     is_still;
    outcome_t outcome;

    modport source (output valid, check_done, is_still, outcome, input ready);
    modport sink   (input valid, check_done, is_still, outcome, output ready);
endinterface

interface sd_cfg_if
    import sd_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/sd_motion.sv -----
// Motion test: compares the squared acceleration magnitude against the band around one g.
`timescale 1ns / 1ps

module sd_motion
    import sd_pkg::*;
(
    input  logic [SQ_W-1:0]  sq_x,
    input  logic [SQ_W-1:0]  sq_y,
    input  logic [SQ_W-1:0]  sq_z,
    input  logic [REF_W-1:0] thr_ref,
    input  logic [LIM_W-1:0] thr_lim,
    output logic             moving
);

    logic [TIME_W-1:0]       sum;
    logic signed [REF_W:0]   diff;
    logic [REF_W:0]          mag;

    always_comb
    begin
        sum  = {1'b0, sq_x} + {1'b0, sq_y} + {1'b0, sq_z};
        diff = $signed({2'b00, sum}) - $signed({1'b0, thr_ref});
        // |x^2+y^2+z^2 - g^2 - t^2| > 2*g*t
        mag  = diff[REF_W] ? $unsigned(-diff) : $unsigned(diff);
        moving = mag > {{(REF_W + 1 - LIM_W){1'b0}}, thr_lim};
    end

endmodule

// ----- sv/stillness_detector_core.sv -----
// Stillness detector top level: config registers, sample register, check state, result register.
// A request is held in the input register, then evaluated, and its result is written to the
// result register. Throughput: one request per cycle while the result side is not stalled,
// limited by the single state update that each request makes in the evaluation stage. rst_n
// (async, low) clears the check state and restores the register defaults: timeout 1000 ms,
// still run 500 ms, threshold 26 (Q8.8), error limit 100.
`timescale 1ns / 1ps

module stillness_detector_core
    import sd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sd_cfg_if.sink        cfg,
    sd_item_if.sink       item,
    sd_result_if.source   result
);

    // Configuration, kept in the scaled form the datapath uses
    logic [US_W-1:0]     timeout_us_reg;
    logic [US_W-1:0]     min_still_us_reg;
    logic [REF_W-1:0]    thr_ref_reg;
    logic [LIM_W-1:0]    thr_lim_reg;
    logic [MAXERR_W-1:0] max_errors_reg;

    logic [TIME_W-1:0]   t_sq;

    // Input register
    logic              s1_valid_reg;
    logic              s1_command_reg;
    logic              s1_sample_valid_reg;
    logic [SQ_W-1:0]   s1_sq_x_reg;
    logic [SQ_W-1:0]   s1_sq_y_reg;
    logic [SQ_W-1:0]   s1_sq_z_reg;
    logic [TIME_W-1:0] s1_now_reg;
    logic signed [2*ACCEL_W-1:0] sq_x_full;
    logic signed [2*ACCEL_W-1:0] sq_y_full;
    logic signed [2*ACCEL_W-1:0] sq_z_full;

    // Check state
    logic              active_reg,   active_next;
    logic [TIME_W-1:0] deadline_reg, deadline_next;
    logic              run_seen_reg, run_seen_next;
    logic [TIME_W-1:0] run_start_reg, run_start_next;
    logic [ERR_W-1:0]  tally_reg,    tally_next;

    // Result register
    logic     out_valid_reg;
    logic     out_done_reg;
    logic     out_still_reg;
    outcome_t out_code_reg, out_code_next;

    logic              advance;
    logic              take;
    logic              moving;
    logic              single;
    logic [TIME_W-1:0] since_deadline;
    logic [TIME_W-1:0] run_len;

    assign cfg.ready = 1'b1;
    assign t_sq      = 32'(cfg.data) * 32'(cfg.data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_us_reg   <= TIMEOUT_US_RESET;
            min_still_us_reg <= MIN_STILL_US_RESET;
            thr_ref_reg      <= THR_REF_RESET;
            thr_lim_reg      <= THR_LIM_RESET;
            max_errors_reg   <= MAX_ERRORS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_TIMEOUT_MS:
                    timeout_us_reg <= US_W'(cfg.data) * US_W'(US_PER_MS);
                CFG_MIN_STILL_MS:
                    min_still_us_reg <= US_W'(cfg.data) * US_W'(US_PER_MS);
                CFG_STILL_THRESHOLD:
                begin
                    thr_ref_reg <= {1'b0, t_sq} + G_SQ;
                    thr_lim_reg <= LIM_W'(cfg.data) * TWO_G;
                end
                CFG_MAX_ERRORS:
                    max_errors_reg <= cfg.data[MAXERR_W-1:0];
                default: ;
            endcase
        end
    end

    // Evaluate the held request when the result register is free or being drained
    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;
    assign take       = item.valid && item.ready;

    assign sq_x_full = item.accel_x * item.accel_x;
    assign sq_y_full = item.accel_y * item.accel_y;
    assign sq_z_full = item.accel_z * item.accel_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_command_reg      <= item.command;
            s1_sample_valid_reg <= item.sample_valid;
            s1_sq_x_reg         <= sq_x_full[SQ_W-1:0];
            s1_sq_y_reg         <= sq_y_full[SQ_W-1:0];
            s1_sq_z_reg         <= sq_z_full[SQ_W-1:0];
            s1_now_reg          <= item.now_us;
        end
    end

    sd_motion u_motion (
        .sq_x    (s1_sq_x_reg),
        .sq_y    (s1_sq_y_reg),
        .sq_z    (s1_sq_z_reg),
        .thr_ref (thr_ref_reg),
        .thr_lim (thr_lim_reg),
        .moving  (moving)
    );

    assign single         = (min_still_us_reg == '0);
    assign since_deadline = s1_now_reg - deadline_reg;
    assign run_len        = s1_now_reg - run_start_reg;

    always_comb
    begin
        active_next    = active_reg;
        deadline_next  = deadline_reg;
        run_seen_next  = run_seen_reg;
        run_start_next = run_start_reg;
        tally_next     = tally_reg;
        out_code_next  = OUT_RUNNING;

        if (command_t'(s1_command_reg) == CMD_START)
        begin
            // Rearm
            active_next    = 1'b1;
            deadline_next  = s1_now_reg + TIME_W'(timeout_us_reg);
            run_seen_next  = 1'b0;
            run_start_next = '0;
            tally_next     = '0;
        end
        else if (!active_reg)
        begin
            out_code_next = OUT_IDLE;
        end
        else if (!since_deadline[TIME_W-1])
        begin
            out_code_next = OUT_DEADLINE;
        end
        else if (!s1_sample_valid_reg)
        begin
            tally_next = tally_reg + 1'b1;
            if (tally_next > {1'b0, max_errors_reg})
            begin
                out_code_next = OUT_ERRORS;
            end
        end
        else if (moving)
        begin
            if (single)
            begin
                out_code_next = OUT_MOVED;
            end
            else
            begin
                run_seen_next = 1'b0;
            end
        end
        else if (single)
        begin
            out_code_next = OUT_STILL;
        end
        else if (!run_seen_reg)
        begin
            run_seen_next  = 1'b1;
            run_start_next = s1_now_reg;
        end
        else if (run_len >= TIME_W'(min_still_us_reg))
        begin
            out_code_next = OUT_STILL;
        end

        case (out_code_next)
            OUT_STILL, OUT_MOVED, OUT_DEADLINE, OUT_ERRORS:
                active_next = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            deadline_reg  <= '0;
            run_seen_reg  <= 1'b0;
            run_start_reg <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                active_reg    <= active_next;
                deadline_reg  <= deadline_next;
                run_seen_reg  <= run_seen_next;
                run_start_reg <= run_start_next;
                tally_reg     <= tally_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_code_reg  <= out_code_next;
            out_still_reg <= (out_code_next == OUT_STILL);
            out_done_reg  <= (out_code_next == OUT_STILL) || (out_code_next == OUT_MOVED) ||
                             (out_code_next == OUT_DEADLINE) || (out_code_next == OUT_ERRORS);
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.check_done = out_done_reg;
    assign result.is_still   = out_still_reg;
    assign result.outcome    = out_code_reg;

endmodule

// ----- tb/sv/stillness_detector_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for stillness_detector_core: directed, random and backpressure checks.

module stillness_detector_core_tb;
    import sd_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 10;
    localparam int LONG_HOLD    = 300;
    localparam logic signed [ACCEL_W-1:0] G_AXIS = ACCEL_W'(G_Q8_8);

    typedef struct {
        command_t                  cmd;
        logic                      sample_ok;
        logic signed [ACCEL_W-1:0] ax;
        logic signed [ACCEL_W-1:0] ay;
        logic signed [ACCEL_W-1:0] az;
        logic [TIME_W-1:0]         now;
    } sample_req_t;

    typedef struct {
        logic     done;
        logic     still;
        outcome_t outcome;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n;

    sd_cfg_if    cfg_ch();
    sd_item_if   item_ch();
    sd_result_if result_ch();

    stillness_detector_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (result_ch)
    );

    // Register copies
    logic [15:0]         timeout_ms_q;
    logic [15:0]         min_still_ms_q;
    logic [15:0]         threshold_q;
    logic [MAXERR_W-1:0] max_errors_q;

    // Check state copies
    logic              armed;
    logic [TIME_W-1:0] deadline;
    logic              run_open;
    logic [TIME_W-1:0] run_start;
    logic [ERR_W-1:0]  invalid_tally;

    verdict_t pending_verdicts[$];
    int       mismatches      = 0;
    int       requests_sent   = 0;
    int       results_checked = 0;
    int       outcome_seen [6];
    bit       send_gaps       = 1'b1;
    bit       recv_gaps       = 1'b1;
    int       hold_cycles     = 0;
    int       quiet_cycles    = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic sample_moving(sample_req_t r);
        longint x, y, z, t, g, dev;
        x   = r.ax;
        y   = r.ay;
        z   = r.az;
        t   = threshold_q;
        g   = G_Q8_8;
        dev = x * x + y * y + z * z - (g * g + t * t);
        if (dev < 0)
        begin
            dev = -dev;
        end
        return dev > 2 * g * t;
    endfunction

    // Advance the check state by one request and return the result it should produce.
    function automatic verdict_t judge_event(sample_req_t r);
        verdict_t          v;
        outcome_t          code;
        logic [TIME_W-1:0] elapsed;
        logic              single;
        single  = (min_still_ms_q == 16'd0);
        elapsed = r.now - deadline;
        if (r.cmd == CMD_START)
        begin
            armed         = 1'b1;
            deadline      = r.now + TIME_W'(timeout_ms_q) * TIME_W'(US_PER_MS);
            run_open      = 1'b0;
            run_start     = '0;
            invalid_tally = '0;
            code          = OUT_RUNNING;
        end
        else if (!armed)
        begin
            code = OUT_IDLE;
        end
        else if (!elapsed[TIME_W-1])
        begin
            code = OUT_DEADLINE;
        end
        else if (!r.sample_ok)
        begin
            invalid_tally = invalid_tally + 1'b1;
            code = (invalid_tally > max_errors_q) ? OUT_ERRORS : OUT_RUNNING;
        end
        else if (sample_moving(r))
        begin
            if (single)
            begin
                code = OUT_MOVED;
            end
            else
            begin
                run_open = 1'b0;
                code     = OUT_RUNNING;
            end
        end
        else if (single)
        begin
            code = OUT_STILL;
        end
        else if (!run_open)
        begin
            run_open  = 1'b1;
            run_start = r.now;
            code      = OUT_RUNNING;
        end
        else
        begin
            elapsed = r.now - run_start;
            code = (elapsed >= TIME_W'(min_still_ms_q) * TIME_W'(US_PER_MS)) ? OUT_STILL
                                                                            : OUT_RUNNING;
        end
        v.done    = (code == OUT_STILL) || (code == OUT_MOVED) || (code == OUT_DEADLINE) ||
                    (code == OUT_ERRORS);
        v.still   = (code == OUT_STILL);
        v.outcome = code;
        if (v.done)
        begin
            armed = 1'b0;
        end
        return v;
    endfunction

    function automatic sample_req_t start_req(logic [TIME_W-1:0] now);
        sample_req_t r;
        r.cmd       = CMD_START;
        r.sample_ok = 1'b0;
        r.ax        = '0;
        r.ay        = '0;
        r.az        = '0;
        r.now       = now;
        return r;
    endfunction

    function automatic sample_req_t sample_req(logic ok, logic signed [ACCEL_W-1:0] x,
                                               logic signed [ACCEL_W-1:0] y,
                                               logic signed [ACCEL_W-1:0] z,
                                               logic [TIME_W-1:0] now);
        sample_req_t r;
        r.cmd       = CMD_SAMPLE;
        r.sample_ok = ok;
        r.ax        = x;
        r.ay        = y;
        r.az        = z;
        r.now       = now;
        return r;
    endfunction

    // Valid sample: a random axis lies dev_lo..dev_hi away from one g, the others within +/-lateral.
    function automatic sample_req_t near_g_sample(logic [TIME_W-1:0] now, int dev_lo, int dev_hi,
                                                  int lateral);
        logic signed [ACCEL_W-1:0] side1, side2, up;
        side1 = ACCEL_W'($urandom_range(0, 2 * lateral)) - ACCEL_W'(lateral);
        side2 = ACCEL_W'($urandom_range(0, 2 * lateral)) - ACCEL_W'(lateral);
        up    = ACCEL_W'($urandom_range(dev_lo, dev_hi));
        up    = $urandom_range(0, 1) ? G_AXIS + up : G_AXIS - up;
        if ($urandom_range(0, 1))
        begin
            up = -up;
        end
        case ($urandom_range(0, 2))
            0:       return sample_req(1'b1, up, side1, side2, now);
            1:       return sample_req(1'b1, side1, up, side2, now);
            default: return sample_req(1'b1, side1, side2, up, now);
        endcase
    endfunction

    task automatic send_request(sample_req_t r);
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.command      <= r.cmd;
        item_ch.sample_valid <= r.sample_ok;
        item_ch.accel_x      <= r.ax;
        item_ch.accel_y      <= r.ay;
        item_ch.accel_z      <= r.az;
        item_ch.now_us       <= r.now;
        do @(posedge clk); while (!item_ch.ready);
        pending_verdicts.push_back(judge_event(r));
        requests_sent++;
    endtask

    // Drop valid and wait until every result is back and the pipeline is empty.
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            CFG_TIMEOUT_MS:      timeout_ms_q   = value;
            CFG_MIN_STILL_MS:    min_still_ms_q = value;
            CFG_STILL_THRESHOLD: threshold_q    = value;
            CFG_MAX_ERRORS:      max_errors_q   = value[MAXERR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [15:0] to_ms, logic [15:0] still_ms, logic [15:0] thr,
                                  logic [MAXERR_W-1:0] err_max);
        settle();
        write_reg(CFG_TIMEOUT_MS, to_ms);
        write_reg(CFG_MIN_STILL_MS, still_ms);
        write_reg(CFG_STILL_THRESHOLD, thr);
        write_reg(CFG_MAX_ERRORS, CFG_DATA_W'(err_max));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic note_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("%0t mismatch: %s", $time, msg);
        end
    endtask

    // Reset register values: idle sample, a wrapping deadline, a broken and a finished still run.
    task automatic test_reset_defaults();
        logic [TIME_W-1:0] t0;
        t0 = 32'hFFFF_0000;
        send_request(sample_req(1'b0, 16'sh8000, 16'sh7FFF, -16'sd1, 32'h0000_0000));
        send_request(start_req(t0));
        send_request(sample_req(1'b0, 16'sh7FFF, 16'sh8000, 16'sh0000, t0 + 1000));
        send_request(sample_req(1'b1, 16'sd0, 16'sd0, G_AXIS, t0 + 2000));
        send_request(sample_req(1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, t0 + 3000));
        send_request(sample_req(1'b1, 16'sd0, 16'sd0, -G_AXIS, t0 + 4000));
        send_request(sample_req(1'b1, 16'sd5, -16'sd5, G_AXIS, t0 + 504000));
        send_request(sample_req(1'b1, 16'sd0, 16'sd0, G_AXIS, t0 + 505000));
    endtask

    // Single-sample decisions: moved at max threshold, exact g at zero threshold, error limit 0.
    task automatic test_single_sample();
        logic [TIME_W-1:0] t0;
        apply_settings(16'hFFFF, 16'h0000, 16'hFFFF, 8'h00);
        send_request(start_req(32'd100));
        send_request(sample_req(1'b1, 16'sd0, 16'sd0, 16'sd0, 32'd200));
        send_request(sample_req(1'b1, 16'sd0, 16'sd0, G_AXIS, 32'd300));
        apply_settings(16'd50, 16'h0000, 16'h0000, 8'h00);
        t0 = 32'h1234_5678;
        send_request(start_req(t0));
        send_request(sample_req(1'b1, 16'sd0, 16'sd0, G_AXIS, t0 + 10));
        send_request(start_req(t0 + 20));
        send_request(sample_req(1'b0, 16'sh7FFF, 16'sh8000, 16'sh5555, t0 + 30));
    endtask

    // Zero timeout ends on the first sample; a 1 ms timeout ends exactly at its deadline.
    task automatic test_deadline();
        logic [TIME_W-1:0] t0;
        apply_settings(16'd0, 16'hFFFF, 16'd26, 8'hFF);
        send_request(start_req(32'd5));
        send_request(sample_req(1'b1, 16'sd0, 16'sd0, G_AXIS, 32'd5));
        apply_settings(16'd1, 16'hFFFF, 16'd26, 8'hFF);
        t0 = 32'h7FFF_FC00;
        send_request(start_req(t0));
        send_request(sample_req(1'b0, 16'sd0, 16'sd0, G_AXIS, t0 + 999));
        send_request(sample_req(1'b1, 16'sd0, 16'sd0, G_AXIS, t0 + 1000));
    endtask

    // Largest error limit: the 256th invalid sample ends the check.
    task automatic test_error_limit();
        logic [TIME_W-1:0] t;
        apply_settings(16'hFFFF, 16'hFFFF, 16'd26, 8'hFF);
        t = $urandom();
        send_request(start_req(t));
        repeat (256)
        begin
            t = t + 100;
            send_request(sample_req(1'b0, ACCEL_W'($urandom()), ACCEL_W'($urandom()),
                                    ACCEL_W'($urandom()), t));
        end
        send_request(sample_req(1'b1, 16'sd0, 16'sd0, G_AXIS, t + 100));
    endtask

    // Random settings, then checks built from mostly well-formed samples with some noise.
    task automatic test_random_phase(int n_items, bit with_gaps);
        logic [15:0]         to_ms, still_ms, thr;
        logic [MAXERR_W-1:0] err_max;
        logic [TIME_W-1:0]   t;
        sample_req_t         r;
        int                  sent, k, kind, step_max;
        case ($urandom_range(0, 9))
            0:       to_ms = 16'd0;
            1:       to_ms = 16'hFFFF;
            default: to_ms = 16'($urandom_range(5, 300));
        endcase
        case ($urandom_range(0, 7))
            0, 1:    still_ms = 16'd0;
            2:       still_ms = 16'hFFFF;
            default: still_ms = 16'($urandom_range(1, 80));
        endcase
        case ($urandom_range(0, 9))
            0:       thr = 16'd0;
            1:       thr = 16'hFFFF;
            default: thr = 16'($urandom_range(8, 200));
        endcase
        case ($urandom_range(0, 5))
            0:       err_max = 8'd0;
            1:       err_max = 8'hFF;
            default: err_max = 8'($urandom_range(1, 8));
        endcase
        apply_settings(to_ms, still_ms, thr, err_max);
        send_gaps = with_gaps && ($urandom_range(0, 3) != 0);
        recv_gaps = with_gaps && ($urandom_range(0, 3) != 0);
        step_max  = 2000 + (int'(still_ms) * 1000) / 6;
        t         = $urandom();
        sent      = 0;
        while (sent < n_items)
        begin
            // Leave out the start now and then so samples land on an idle block.
            if ($urandom_range(0, 9) != 0)
            begin
                send_request(start_req(t));
                sent++;
            end
            k = $urandom_range(1, 40);
            for (int i = 0; i < k && sent < n_items; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    t = t + $urandom();
                end
                else
                begin
                    t = t + $urandom_range(0, step_max);
                end
                kind = $urandom_range(0, 99);
                if (kind < 60)
                begin
                    r = near_g_sample(t, 0, 20, 80);
                end
                else if (kind < 78)
                begin
                    r = near_g_sample(t, 300, 6000, 2000);
                end
                else
                begin
                    r = sample_req(1'b0, ACCEL_W'($urandom()), ACCEL_W'($urandom()),
                                   ACCEL_W'($urandom()), t);
                    if (kind >= 93)
                    begin
                        r.sample_ok = $urandom_range(0, 1);
                        r.cmd       = command_t'($urandom_range(0, 1));
                    end
                end
                send_request(r);
                sent++;
            end
        end
    endtask

    // Hold the result side off while requests keep coming, so the block backs up.
    task automatic test_backpressure();
        logic [TIME_W-1:0] t;
        settle();
        send_gaps   = 1'b0;
        recv_gaps   = 1'b0;
        hold_cycles = LONG_HOLD;
        t           = $urandom();
        send_request(start_req(t));
        repeat (50)
        begin
            t = t + $urandom_range(0, 3000);
            send_request(near_g_sample(t, 0, 20, 80));
        end
    endtask

    // Result side: random stall bursts, plus a long hold on request.
    initial
    begin
        int stall;
        stall = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                stall--;
            end
            else if (recv_gaps && $urandom_range(0, 7) == 0)
            begin
                result_ch.ready <= 1'b0;
                stall = $urandom_range(0, 18);
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_checked++;
            if (!$isunknown(result_ch.outcome) && result_ch.outcome <= OUT_IDLE)
            begin
                outcome_seen[result_ch.outcome]++;
            end
            if (pending_verdicts.size() == 0)
            begin
                note_mismatch($sformatf("result %0b/%0b/%0d with no request pending",
                                        result_ch.check_done, result_ch.is_still,
                                        result_ch.outcome));
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (result_ch.check_done !== want.done || result_ch.is_still !== want.still ||
                    result_ch.outcome !== want.outcome)
                begin
                    note_mismatch($sformatf(
                        "done/still/outcome expected %0b/%0b/%0d, got %0b/%0b/%0d",
                        want.done, want.still, want.outcome, result_ch.check_done,
                        result_ch.is_still, result_ch.outcome));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_verdicts.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n                <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.command      <= CMD_SAMPLE;
        item_ch.sample_valid <= 1'b0;
        item_ch.accel_x      <= '0;
        item_ch.accel_y      <= '0;
        item_ch.accel_z      <= '0;
        item_ch.now_us       <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= CFG_TIMEOUT_MS;
        cfg_ch.data          <= '0;
        timeout_ms_q         = 16'd1000;
        min_still_ms_q       = 16'd500;
        threshold_q          = 16'd26;
        max_errors_q         = MAX_ERRORS_RESET;
        armed                = 1'b0;
        deadline             = '0;
        run_open             = 1'b0;
        run_start            = '0;
        invalid_tally        = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_single_sample();
        test_deadline();
        test_error_limit();
        repeat (7) test_random_phase(100, 1'b1);
        test_backpressure();
        test_random_phase(80, 1'b0);
        settle();

        $display("summary: %0d requests sent, %0d results checked, %0d mismatches",
                 requests_sent, results_checked, mismatches);
        $display("summary: running %0d, still %0d, moved %0d, deadline %0d, errors %0d, idle %0d",
                 outcome_seen[OUT_RUNNING], outcome_seen[OUT_STILL], outcome_seen[OUT_MOVED],
                 outcome_seen[OUT_DEADLINE], outcome_seen[OUT_ERRORS], outcome_seen[OUT_IDLE]);
        if (mismatches == 0 && pending_verdicts.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/sd_pkg.sv
sv/sd_if.sv
sv/sd_motion.sv
sv/stillness_detector_core.sv
tb/sv/stillness_detector_core_tb.sv
